@@ hw/rtl/bitplane_pixel_run_writer_unit_macros.svh @@
// Assertion macros shared by the dot writer RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef BITPLANE_PIXEL_RUN_WRITER_UNIT_MACROS_SVH
`define BITPLANE_PIXEL_RUN_WRITER_UNIT_MACROS_SVH

// same-cycle implication
`define BPRW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPRW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bprw_pkg.sv @@
// Package for the bit-plane dot writer: codes, state type, control structs.
// No dependencies.
`timescale 1ns / 1ps

package bprw_pkg;

    localparam int LINE_BYTES_DEF = 20;
    localparam int MEM_BYTES_DEF  = 8192;

    localparam int FUNC_W   = 2;
    localparam int X_W      = 8;
    localparam int Y_W      = 7;
    localparam int ROWS_W   = 4;
    localparam int DOTS_W   = 5;
    localparam int RADDR_W  = 13;
    localparam int DATA_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 13;

    localparam logic [ROWS_W-1:0] MAX_ROWS = 4'd8;
    localparam logic [CFG_W-1:0] SCREEN2_BASE_RST = 13'd4096;

    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN2_BASE = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_RD_BYTE,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_DONE
    } bprw_state_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic reduce_step;
        logic mem_rd;
        logic row_wr;
        logic out_load;
    } bprw_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic reduce_last;
        logic is_read;
        logic is_write;
        logic no_rows;
        logic last_row;
        logic out_free;
    } bprw_sts_t;

endpackage

@@ hw/rtl/bprw_ctrl.sv @@
// Sequencer for the dot writer: clearing pass, address reduction, row RMW, result.
// Depends on bprw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bitplane_pixel_run_writer_unit_macros.svh"

module bprw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bprw_pkg::bprw_sts_t sts,
    output bprw_pkg::bprw_cmd_t cmd
);

    bprw_pkg::bprw_state_t state_reg;
    bprw_pkg::bprw_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bprw_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            bprw_pkg::ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (sts.clear_done) begin
                    state_next = bprw_pkg::ST_IDLE;
                end
            end
            bprw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = bprw_pkg::ST_REDUCE;
                end
            end
            bprw_pkg::ST_REDUCE: begin
                priority if (!sts.is_read && !sts.is_write) begin
                    state_next = bprw_pkg::ST_DONE;
                end else begin
                    cmd.reduce_step = 1'b1;
                    if (sts.reduce_last) begin
                        priority if (sts.is_read) begin
                            state_next = bprw_pkg::ST_RD_BYTE;
                        end else if (sts.no_rows) begin
                            state_next = bprw_pkg::ST_DONE;
                        end else begin
                            state_next = bprw_pkg::ST_ROW_RD;
                        end
                    end
                end
            end
            bprw_pkg::ST_RD_BYTE: begin
                cmd.mem_rd = 1'b1;
                state_next = bprw_pkg::ST_DONE;
            end
            bprw_pkg::ST_ROW_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = bprw_pkg::ST_ROW_WR;
            end
            bprw_pkg::ST_ROW_WR: begin
                cmd.row_wr = 1'b1;
                state_next = sts.last_row ? bprw_pkg::ST_DONE : bprw_pkg::ST_ROW_RD;
            end
            bprw_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = bprw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bprw_pkg::ST_CLEAR;
            end
        endcase
    end

    // a row write always uses the byte fetched the cycle before
    `BPRW_ASSERT_IMP(a_wr_after_rd, cmd.row_wr, $past(cmd.mem_rd), "row write without fetch")
    // never overwrite a result still waiting downstream
    `BPRW_ASSERT_IMP(a_out_free, cmd.out_load, sts.out_free, "result overwritten")
    // reduction stops once the last step is taken
    `BPRW_ASSERT_NXT(a_red_end, cmd.reduce_step && sts.reduce_last, !cmd.reduce_step,
                     "reduction ran past its last step")

endmodule

@@ hw/rtl/bprw_datapath.sv @@
// Datapath for the dot writer: config registers, mask build, address reduction,
// display memory with clearing counter, output register. Depends on bprw_pkg.
`timescale 1ns / 1ps
`include "bitplane_pixel_run_writer_unit_macros.svh"

module bprw_datapath #(
    parameter int LINE_BYTES = bprw_pkg::LINE_BYTES_DEF,
    parameter int MEM_BYTES  = bprw_pkg::MEM_BYTES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic        [bprw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [bprw_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic        [bprw_pkg::FUNC_W-1:0]     s_func,
    input  logic        [bprw_pkg::X_W-1:0]        s_x_pos,
    input  logic        [bprw_pkg::Y_W-1:0]        s_y_pos,
    input  logic        [bprw_pkg::ROWS_W-1:0]     s_row_count,
    input  logic signed [bprw_pkg::DOTS_W-1:0]     s_dot_count,
    input  logic        [bprw_pkg::RADDR_W-1:0]    s_read_addr,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bprw_pkg::DOTS_W-1:0]     m_used_count,
    output logic        [bprw_pkg::DATA_W-1:0]     m_read_data,
    input  bprw_pkg::bprw_cmd_t                    cmd,
    output bprw_pkg::bprw_sts_t                    sts
);

    localparam int AW = $clog2(MEM_BYTES);
    // widest pre-wrap sum: row base + column byte + second-screen offset
    localparam int SUM_W = $clog2(127 * LINE_BYTES + 31 + 8191 + MEM_BYTES + 1);
    localparam int RED_STEPS = SUM_W - AW + 1;
    localparam int RC_W = $clog2(RED_STEPS);
    localparam int OFF_K = MEM_BYTES - ((64 * LINE_BYTES) % MEM_BYTES);
    localparam logic [bprw_pkg::ROWS_W-1:0] ROWS_ONE = 4'd1;

    // config
    logic                           split_reg;
    logic [bprw_pkg::CFG_W-1:0]     screen2_base_reg;

    // item
    logic [bprw_pkg::FUNC_W-1:0]    func_reg;
    logic [bprw_pkg::ROWS_W-1:0]    rows_reg;
    logic [bprw_pkg::DATA_W-1:0]    mask_reg;
    logic signed [bprw_pkg::DOTS_W-1:0] used_reg;
    logic [SUM_W-1:0]               acc_reg;
    logic [SUM_W:0]                 mod_reg;
    logic [RC_W-1:0]                red_cnt_reg;

    // memory
    logic [bprw_pkg::DATA_W-1:0]    mem [MEM_BYTES];
    logic [bprw_pkg::DATA_W-1:0]    mem_rdata_reg;
    logic [AW-1:0]                  clr_addr_reg;

    // output
    logic                           m_valid_reg;
    logic signed [bprw_pkg::DOTS_W-1:0] m_used_count_reg;
    logic [bprw_pkg::DATA_W-1:0]    m_read_data_reg;

    logic                           is_read;
    logic                           is_write;
    logic [SUM_W-1:0]               start_sum;
    logic [SUM_W-1:0]               split_add;
    logic [bprw_pkg::DATA_W-1:0]    mask_w;
    logic signed [bprw_pkg::DOTS_W-1:0] used_w;
    logic [AW:0]                    row_step;
    logic [AW:0]                    row_next;
    logic [AW-1:0]                  acc_addr;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [bprw_pkg::DATA_W-1:0]    mem_wdata;

    assign is_read  = (func_reg == bprw_pkg::FUNC_READ);
    assign is_write = (func_reg == bprw_pkg::FUNC_SET) || (func_reg == bprw_pkg::FUNC_CLR);
    assign acc_addr = acc_reg[AW-1:0];

    // run mask inside one byte, clipped at the byte edge
    always_comb begin
        int b_i;
        int req_i;
        int used_i;
        b_i   = 7 - int'(s_x_pos[2:0]);
        req_i = int'(s_dot_count);
        if (req_i >= 0) begin
            used_i = (req_i < b_i + 1) ? req_i : b_i + 1;
        end else begin
            used_i = (req_i > b_i - 8) ? req_i : b_i - 8;
        end
        for (int i = 0; i < bprw_pkg::DATA_W; i++) begin
            if (used_i >= 0) begin
                mask_w[i] = (i <= b_i) && (i > b_i - used_i);
            end else begin
                mask_w[i] = (i >= b_i) && (i < b_i - used_i);
            end
        end
        used_w = used_i[bprw_pkg::DOTS_W-1:0];
        if (!((s_func == bprw_pkg::FUNC_SET) || (s_func == bprw_pkg::FUNC_CLR))) begin
            used_w = '0;
        end
    end

    // unwrapped start address; reduced modulo MEM_BYTES afterwards
    always_comb begin
        split_add = '0;
        if (split_reg && s_y_pos[bprw_pkg::Y_W-1]) begin
            split_add = SUM_W'(screen2_base_reg) + SUM_W'(OFF_K);
        end
        if (s_func == bprw_pkg::FUNC_READ) begin
            start_sum = SUM_W'(s_read_addr);
        end else begin
            start_sum = SUM_W'(s_y_pos) * SUM_W'(LINE_BYTES)
                      + SUM_W'(s_x_pos[bprw_pkg::X_W-1:3]) + split_add;
        end
    end

    // next row, wrapped with one compare and subtract
    always_comb begin
        row_step = {1'b0, acc_addr} + (AW+1)'(LINE_BYTES);
        row_next = row_step;
        if (row_step >= (AW+1)'(MEM_BYTES)) begin
            row_next = row_step - (AW+1)'(MEM_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_reg        <= 1'b0;
            screen2_base_reg <= bprw_pkg::SCREEN2_BASE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bprw_pkg::CFG_SPLIT_ENABLE: split_reg        <= cfg_wdata[0];
                bprw_pkg::CFG_SCREEN2_BASE: screen2_base_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg    <= s_func;
            rows_reg    <= (s_row_count > bprw_pkg::MAX_ROWS) ? bprw_pkg::MAX_ROWS
                                                              : s_row_count;
            mask_reg    <= mask_w;
            used_reg    <= used_w;
            acc_reg     <= start_sum;
            mod_reg     <= (SUM_W+1)'(MEM_BYTES) << (RED_STEPS - 1);
            red_cnt_reg <= RC_W'(RED_STEPS - 1);
        end else if (cmd.reduce_step) begin
            // restoring reduction, one multiple of MEM_BYTES per cycle
            if ({1'b0, acc_reg} >= mod_reg) begin
                acc_reg <= acc_reg - mod_reg[SUM_W-1:0];
            end
            mod_reg     <= mod_reg >> 1;
            red_cnt_reg <= red_cnt_reg - 1'b1;
        end else if (cmd.row_wr) begin
            acc_reg  <= SUM_W'(row_next[AW-1:0]);
            rows_reg <= rows_reg - 1'b1;
        end
    end

    // clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign mem_we    = cmd.clear_en || cmd.row_wr;
    assign mem_waddr = cmd.clear_en ? clr_addr_reg : acc_addr;
    always_comb begin
        if (cmd.clear_en) begin
            mem_wdata = '0;
        end else if (func_reg == bprw_pkg::FUNC_SET) begin
            mem_wdata = mem_rdata_reg | mask_reg;
        end else begin
            mem_wdata = mem_rdata_reg & ~mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            mem_rdata_reg <= mem[acc_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_used_count_reg <= used_reg;
            m_read_data_reg  <= is_read ? mem_rdata_reg : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_used_count = m_used_count_reg;
    assign m_read_data  = m_read_data_reg;

    assign sts.clear_done  = (clr_addr_reg == AW'(MEM_BYTES - 1));
    assign sts.reduce_last = (red_cnt_reg == '0);
    assign sts.is_read     = is_read;
    assign sts.is_write    = is_write;
    assign sts.no_rows     = (rows_reg == '0);
    assign sts.last_row    = (rows_reg == ROWS_ONE);
    assign sts.out_free    = !m_valid_reg || m_ready;

    // memory is only addressed once the address is fully wrapped
    `BPRW_ASSERT_IMP(a_addr_wrapped, cmd.mem_rd || cmd.row_wr,
                     acc_reg < SUM_W'(MEM_BYTES), "unwrapped memory address")
    // a loaded result shows up on the port next cycle
    `BPRW_ASSERT_NXT(a_out_shown, cmd.out_load, m_valid, "result not presented")

endmodule

@@ hw/rtl/bitplane_pixel_run_writer_unit.sv @@
// Top level of the bit-plane dot writer: controller plus datapath.
// Depends on bprw_pkg, bprw_ctrl and bprw_datapath.
`timescale 1ns / 1ps

// After reset the block runs a clearing pass over the display memory, one byte
// per cycle, and takes no item until it ends; configuration writes are taken
// throughout. Each item is then handled alone: an accept step, a restoring
// reduction that wraps the start address modulo MEM_BYTES, then, for a set or
// clear, a read-modify-write of one byte per row through the single memory
// port (up to 8 rows) or, for a read, one byte fetch, and last a load of the
// output register once it is free. The next item is accepted while a result
// waits in the output register.
module bitplane_pixel_run_writer_unit #(
    parameter int LINE_BYTES = bprw_pkg::LINE_BYTES_DEF,
    parameter int MEM_BYTES  = bprw_pkg::MEM_BYTES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic        [bprw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [bprw_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic        [bprw_pkg::FUNC_W-1:0]     s_func,
    input  logic        [bprw_pkg::X_W-1:0]        s_x_pos,
    input  logic        [bprw_pkg::Y_W-1:0]        s_y_pos,
    input  logic        [bprw_pkg::ROWS_W-1:0]     s_row_count,
    input  logic signed [bprw_pkg::DOTS_W-1:0]     s_dot_count,
    input  logic        [bprw_pkg::RADDR_W-1:0]    s_read_addr,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bprw_pkg::DOTS_W-1:0]     m_used_count,
    output logic        [bprw_pkg::DATA_W-1:0]     m_read_data
);

    bprw_pkg::bprw_cmd_t cmd;
    bprw_pkg::bprw_sts_t sts;

    bprw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bprw_datapath #(
        .LINE_BYTES (LINE_BYTES),
        .MEM_BYTES  (MEM_BYTES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_func       (s_func),
        .s_x_pos      (s_x_pos),
        .s_y_pos      (s_y_pos),
        .s_row_count  (s_row_count),
        .s_dot_count  (s_dot_count),
        .s_read_addr  (s_read_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_used_count (m_used_count),
        .m_read_data  (m_read_data),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
